[rtl/core/xtee_pkg.sv]
// Shared types, codes and character tables of the XML text escape encoder.
package xtee_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_NAMED = 2'd1;
  localparam logic [1:0] KIND_HEX   = 2'd2;

  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_LT   = 3'd1;
  localparam logic [2:0] ENT_GT   = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_NBSP = 3'd4;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;

  localparam logic [15:0] CODE_NBSP = 16'h00a0;

  // One queued unit of output work.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ent;
    logic [1:0]  ndig_m1;
    logic [15:0] code;
  } job_t;

  function automatic logic [2:0] ent_len(input logic [2:0] ent);
    logic [2:0] len;
    unique case (ent)
      ENT_AMP:  len = 3'd5;
      ENT_LT:   len = 3'd4;
      ENT_GT:   len = 3'd4;
      ENT_QUOT: len = 3'd6;
      ENT_NBSP: len = 3'd6;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  // Entity text, right-justified, first character in the highest used byte.
  function automatic logic [47:0] ent_text(input logic [2:0] ent);
    logic [47:0] txt;
    unique case (ent)
      ENT_AMP:  txt = 48'("&amp;");
      ENT_LT:   txt = 48'("&lt;");
      ENT_GT:   txt = 48'("&gt;");
      ENT_QUOT: txt = 48'("&quot;");
      ENT_NBSP: txt = 48'("&nbsp;");
      default:  txt = '0;
    endcase
    return txt;
  endfunction

  function automatic logic [2:0] job_last_idx(input job_t j);
    logic [2:0] li;
    unique case (j.kind)
      KIND_BYTE:  li = 3'd0;
      KIND_NAMED: li = ent_len(j.ent) - 3'd1;
      KIND_HEX:   li = 3'({1'b0, j.ndig_m1}) + 3'd4;
      default:    li = 3'd0;
    endcase
    return li;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + 8'(nib);
    end else begin
      ch = CH_A + 8'(nib - 4'd10);
    end
    return ch;
  endfunction

  function automatic logic [7:0] job_char(input job_t j, input logic [2:0] idx);
    logic [7:0]  ch;
    logic [47:0] txt;
    logic [2:0]  pos;
    logic [1:0]  ni;
    logic [3:0]  nib;
    ch  = 8'h00;
    txt = ent_text(j.ent);
    pos = ent_len(j.ent) - 3'd1 - idx;
    ni  = 2'({1'b0, j.ndig_m1} - (idx - 3'd3));
    unique case (ni)
      2'd0:    nib = j.code[3:0];
      2'd1:    nib = j.code[7:4];
      2'd2:    nib = j.code[11:8];
      default: nib = j.code[15:12];
    endcase
    unique case (j.kind)
      KIND_BYTE: ch = j.code[7:0];
      KIND_NAMED: begin
        for (int k = 0; k < 6; k++) begin
          if (3'(k) == pos) ch = txt[8*k +: 8];
        end
      end
      KIND_HEX: begin
        if (idx == 3'd0) ch = CH_AMP;
        else if (idx == 3'd1) ch = CH_HASH;
        else if (idx == 3'd2) ch = CH_X;
        else if (idx == job_last_idx(j)) ch = CH_SEMI;
        else ch = hex_char(nib);
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[rtl/core/xml_text_escape_encoder.sv]
// XML text escape encoder top level: front decode, job queue and byte expansion.
// One input transaction (a text byte or an end-of-string marker) is taken per
// cycle while the job queue has room. An input produces 1 output byte for
// plain text, 4 to 6 for a named entity, 5 to 8 for a hex character reference,
// and 0 for a lead or non-final continuation byte. Output throughput is one byte
// per cycle while out_stall is low, set by the single expansion counter in the
// back end. in_stall is high whenever the QUEUE_DEPTH job queue is full. The
// queue lets inputs keep flowing while a long entity is emitted. The first
// output byte of an input passes through the queue register and then the
// output register, if the queue ahead of it is empty. A sequence whose
// continuation bytes are missing is flushed at end of string, and the missing
// bits are taken as zero.
module xml_text_escape_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  xtee_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xtee_pkg::out_item_t out_data
);
  import xtee_pkg::*;

  logic in_take;
  logic job_push;
  job_t job;
  job_t head;
  logic empty;
  logic full;
  logic pop;

  assign in_stall = full;
  assign in_take  = in_valid && !full;

  xtee_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job)
  );

  xtee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  xtee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/xtee_front.sv]
// Front end: multi-byte sequence decode and classification of input transactions.
module xtee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  xtee_pkg::in_item_t in_data,
  output logic              job_push,
  output xtee_pkg::job_t    job
);
  import xtee_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] code;
  logic [15:0] acc_new;
  logic        emit_code;
  logic        emit;
  logic [7:0]  b;

  always_comb begin
    b         = in_data.in_byte;
    pending_nxt = pending_r;
    acc_nxt   = acc_r;
    code      = '0;
    emit_code = 1'b0;
    emit      = 1'b0;
    acc_new   = {acc_r[9:0], b[5:0]};
    job       = '0;
    job.kind  = KIND_BYTE;
    if (in_data.end_of_string) begin
      if (pending_r != 2'd0) begin
        code        = (pending_r == 2'd1) ? {acc_r[9:0], 6'b0} : {acc_r[3:0], 12'b0};
        emit_code   = 1'b1;
        pending_nxt = 2'd0;
        acc_nxt     = '0;
      end
    end else if (pending_r != 2'd0) begin
      acc_nxt     = acc_new;
      pending_nxt = pending_r - 2'd1;
      if (pending_r == 2'd1) begin
        code      = acc_new;
        emit_code = 1'b1;
        acc_nxt   = '0;
      end
    end else if (b == CH_AMP) begin
      emit = 1'b1; job.kind = KIND_NAMED; job.ent = ENT_AMP;
    end else if (b == CH_LT) begin
      emit = 1'b1; job.kind = KIND_NAMED; job.ent = ENT_LT;
    end else if (b == CH_GT) begin
      emit = 1'b1; job.kind = KIND_NAMED; job.ent = ENT_GT;
    end else if (b == CH_QUOT) begin
      emit = 1'b1; job.kind = KIND_NAMED; job.ent = ENT_QUOT;
    end else if (!b[7]) begin
      emit = 1'b1; job.kind = KIND_BYTE; job.code = {8'h00, b};
    end else if (b[7:5] == 3'b110) begin
      acc_nxt     = {11'b0, b[4:0]};
      pending_nxt = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_nxt     = {12'b0, b[3:0]};
      pending_nxt = 2'd2;
    end else begin
      code      = {8'h00, b};
      emit_code = 1'b1;
    end

    if (emit_code) begin
      emit     = 1'b1;
      job.code = code;
      if (code == CODE_NBSP) begin
        job.kind = KIND_NAMED;
        job.ent  = ENT_NBSP;
      end else begin
        job.kind = KIND_HEX;
        if (code[15:12] != 4'd0) job.ndig_m1 = 2'd3;
        else if (code[11:8] != 4'd0) job.ndig_m1 = 2'd2;
        else if (code[7:4] != 4'd0) job.ndig_m1 = 2'd1;
        else job.ndig_m1 = 2'd0;
      end
    end
  end

  assign job_push = in_take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      acc_r     <= '0;
    end else if (in_take) begin
      pending_r <= pending_nxt;
      acc_r     <= acc_nxt;
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("front: pending count out of range");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && in_data.end_of_string |=> acc_r == 16'd0)
    else $error("front: accumulator not cleared after flush");

endmodule

[rtl/core/xtee_queue.sv]
// Short register queue of jobs between front and back end.
module xtee_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xtee_pkg::job_t push_job,
  input  logic           pop,
  output xtee_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import xtee_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue: pop while empty");

endmodule

[rtl/core/xtee_back.sv]
// Back end: expands queued jobs into output bytes behind an output register.
module xtee_back (
  input  logic               clk,
  input  logic               rst_n,
  input  xtee_pkg::job_t     head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output xtee_pkg::out_item_t out_data
);
  import xtee_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic       at_last;

  assign load    = !out_valid_r || !out_stall;
  assign at_last = (idx_r == job_last_idx(head));
  assign pop     = load && !empty && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_data_nxt.out_byte    = job_char(head, idx_r);
        out_data_nxt.last_of_run = at_last;
        idx_nxt                  = at_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> !empty)
    else $error("back: job in progress but queue empty");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> idx_r <= job_last_idx(head))
    else $error("back: character index past end of job");

endmodule
